@@ design/kssq_pkg.sv @@
// Package for the kiln saw station sequencer: beat structs, register indexes,
// phase codes, sub-step codes and actuator bit positions. No dependencies.
`timescale 1ns / 1ps

package kssq_pkg;

  // One input beat: sensor snapshot taken on one timer tick.
  typedef struct packed {
    logic kiln_barrier_clear;
    logic feeder_inside;
    logic feeder_outside;
    logic gripper_at_kiln;
    logic gripper_at_table;
    logic table_at_suction;
    logic table_at_saw;
    logic table_at_conveyor;
    logic exit_barrier_clear;
  } in_beat_t;

  // One result beat: latched actuator word and current phase.
  typedef struct packed {
    logic [13:0] actuator_word;
    logic [3:0]  phase;
  } out_beat_t;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned ACT_W      = 14;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WAIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRE       = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAW        = 8'd3;

  // Reset values of the timing registers.
  localparam logic [TICK_W-1:0] SHORT_WAIT_RST = 16'd500;
  localparam logic [TICK_W-1:0] LONG_WAIT_RST  = 16'd1000;
  localparam logic [TICK_W-1:0] FIRE_RST       = 16'd3000;
  localparam logic [TICK_W-1:0] SAW_RST        = 16'd5000;

  typedef struct packed {
    logic [TICK_W-1:0] short_wait;
    logic [TICK_W-1:0] long_wait;
    logic [TICK_W-1:0] fire;
    logic [TICK_W-1:0] saw;
  } timing_cfg_t;

  // Station phases, in cycle order.
  typedef enum logic [3:0] {
    PH_WAITING  = 4'd0,
    PH_FEED     = 4'd1,
    PH_FIRING   = 4'd2,
    PH_FIRED    = 4'd3,
    PH_TO_KILN  = 4'd4,
    PH_PICK     = 4'd5,
    PH_PLACE    = 4'd6,
    PH_SAWING   = 4'd7,
    PH_EJECT    = 4'd8,
    PH_HOMING   = 4'd9,
    PH_CONVEYOR = 4'd10
  } phase_t;

  // Sub-step codes within a phase.
  localparam logic [2:0] SS_ENTRY  = 3'd0;
  localparam logic [2:0] SS_FIRST  = 3'd1;
  localparam logic [2:0] SS_SECOND = 3'd2;
  localparam logic [2:0] SS_THIRD  = 3'd3;

  // Actuator bit positions.
  localparam int unsigned A_CW      = 0;
  localparam int unsigned A_CCW     = 1;
  localparam int unsigned A_CONV    = 2;
  localparam int unsigned A_SAW     = 3;
  localparam int unsigned A_RETRACT = 4;
  localparam int unsigned A_EXTEND  = 5;
  localparam int unsigned A_TOKILN  = 6;
  localparam int unsigned A_TOTABLE = 7;
  localparam int unsigned A_LAMP    = 8;
  localparam int unsigned A_COMP    = 9;
  localparam int unsigned A_VACUUM  = 10;
  localparam int unsigned A_LOWER   = 11;
  localparam int unsigned A_DOOR    = 12;
  localparam int unsigned A_EJECTOR = 13;

  // Sequencer state carried from tick to tick.
  typedef struct packed {
    phase_t            phase;
    logic [2:0]        sub_step;
    logic [TICK_W-1:0] wait_count;
    logic [ACT_W-1:0]  latch;
  } seq_state_t;

endpackage

@@ design/kssq_cfg_regs.sv @@
// Timing register file of the kiln saw station sequencer.
// Depends on kssq_pkg for register indexes and reset values.
`timescale 1ns / 1ps

module kssq_cfg_regs
  import kssq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [TICK_W-1:0]    wr_data,
  output timing_cfg_t          cfg
);

  timing_cfg_t cfg_r;
  timing_cfg_t cfg_nxt;

  // Decode the write; indexes past the last register are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_SHORT_WAIT: cfg_nxt.short_wait = wr_data;
        CFG_LONG_WAIT:  cfg_nxt.long_wait  = wr_data;
        CFG_FIRE:       cfg_nxt.fire       = wr_data;
        CFG_SAW:        cfg_nxt.saw        = wr_data;
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_wait <= SHORT_WAIT_RST;
      cfg_r.long_wait  <= LONG_WAIT_RST;
      cfg_r.fire       <= FIRE_RST;
      cfg_r.saw        <= SAW_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/kssq_step.sv @@
// One-tick state update of the station sequencer: pause countdown, phase
// walk and actuator latch. Purely combinational; depends on kssq_pkg.
`timescale 1ns / 1ps

module kssq_step
  import kssq_pkg::*;
(
  input  seq_state_t  cur,
  input  in_beat_t    sense,
  input  timing_cfg_t cfg,
  output seq_state_t  nxt
);

  logic              run;
  logic [TICK_W-1:0] wait_dec;

  assign wait_dec = cur.wait_count - TICK_W'(1);

  always_comb begin
    nxt = cur;
    run = 1'b1;
    nxt.latch[A_COMP] = 1'b1;

    // A running pause counts down and holds off the sequencer.
    if (cur.wait_count != '0) begin
      nxt.wait_count = wait_dec;
      if (wait_dec != '0) begin
        run = 1'b0;
      end
    end

    if (run) begin
      unique case (cur.phase)
        PH_WAITING: begin
          if (cur.sub_step == SS_FIRST) begin
            nxt.phase = PH_FEED; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end else if (!sense.kiln_barrier_clear) begin
            nxt.wait_count = cfg.short_wait; nxt.sub_step = SS_FIRST;
          end
        end
        PH_FEED: begin
          nxt.latch[A_DOOR] = 1'b1;
          if (!sense.feeder_inside) begin
            nxt.latch[A_RETRACT] = 1'b1;
          end else begin
            nxt.latch[A_RETRACT] = 1'b0;
            nxt.phase = PH_FIRING; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end
        end
        PH_FIRING: begin
          if (cur.sub_step == SS_FIRST) begin
            nxt.latch[A_LAMP] = 1'b0;
            nxt.phase = PH_FIRED; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end else begin
            nxt.latch[A_DOOR] = 1'b0;
            nxt.latch[A_LAMP] = 1'b1;
            nxt.wait_count = cfg.fire; nxt.sub_step = SS_FIRST;
          end
        end
        PH_FIRED: begin
          if (cur.sub_step == SS_FIRST) begin
            nxt.latch[A_EXTEND] = 1'b1;
            if (sense.feeder_outside) begin
              nxt.latch[A_EXTEND] = 1'b0;
              nxt.latch[A_DOOR]   = 1'b0;
              nxt.phase = PH_TO_KILN; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
            end
          end else begin
            nxt.latch[A_DOOR] = 1'b1;
            nxt.wait_count = cfg.short_wait; nxt.sub_step = SS_FIRST;
          end
        end
        PH_TO_KILN: begin
          if (!sense.gripper_at_kiln) begin
            nxt.latch[A_TOKILN] = 1'b1;
          end else begin
            nxt.latch[A_TOKILN] = 1'b0;
            nxt.phase = PH_PICK; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end
        end
        PH_PICK: begin
          if (cur.sub_step == SS_FIRST) begin
            nxt.latch[A_VACUUM] = 1'b1;
            nxt.latch[A_LOWER]  = 1'b0;
            nxt.wait_count = cfg.short_wait; nxt.sub_step = SS_SECOND;
          end else if (cur.sub_step == SS_SECOND) begin
            nxt.phase = PH_PLACE; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end else begin
            nxt.latch[A_LOWER] = 1'b1;
            nxt.wait_count = cfg.long_wait; nxt.sub_step = SS_FIRST;
          end
        end
        PH_PLACE: begin
          if (cur.sub_step == SS_FIRST) begin
            nxt.latch[A_VACUUM] = 1'b0;
            nxt.wait_count = cfg.short_wait; nxt.sub_step = SS_SECOND;
          end else if (cur.sub_step == SS_SECOND) begin
            nxt.latch[A_LOWER] = 1'b0;
            nxt.wait_count = cfg.long_wait; nxt.sub_step = SS_THIRD;
          end else if (cur.sub_step == SS_THIRD) begin
            nxt.phase = PH_SAWING; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end else if (!sense.gripper_at_table) begin
            nxt.latch[A_TOTABLE] = 1'b1;
          end else begin
            nxt.latch[A_TOTABLE] = 1'b0;
            if (!sense.table_at_suction) begin
              nxt.latch[A_CCW] = 1'b1;
            end else begin
              nxt.latch[A_CCW]   = 1'b0;
              nxt.latch[A_LOWER] = 1'b1;
              nxt.wait_count = cfg.long_wait; nxt.sub_step = SS_FIRST;
            end
          end
        end
        PH_SAWING: begin
          if (cur.sub_step == SS_FIRST) begin
            nxt.latch[A_SAW] = 1'b0;
            nxt.phase = PH_EJECT; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end else if (!sense.table_at_saw) begin
            nxt.latch[A_CW] = 1'b1;
          end else begin
            nxt.latch[A_CW]  = 1'b0;
            nxt.latch[A_SAW] = 1'b1;
            nxt.wait_count = cfg.saw; nxt.sub_step = SS_FIRST;
          end
        end
        PH_EJECT: begin
          if (cur.sub_step == SS_FIRST) begin
            nxt.latch[A_EJECTOR] = 1'b0;
            nxt.phase = PH_HOMING; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end else if (!sense.table_at_conveyor) begin
            nxt.latch[A_CW] = 1'b1;
          end else begin
            nxt.latch[A_CW]      = 1'b0;
            nxt.latch[A_EJECTOR] = 1'b1;
            nxt.wait_count = cfg.short_wait; nxt.sub_step = SS_FIRST;
          end
        end
        PH_HOMING: begin
          if (!sense.table_at_suction) begin
            nxt.latch[A_CCW] = 1'b1;
          end else begin
            nxt.latch[A_CCW] = 1'b0;
            nxt.phase = PH_CONVEYOR; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end
        end
        PH_CONVEYOR: begin
          if (cur.sub_step == SS_FIRST) begin
            nxt.latch[A_CONV] = 1'b0;
            nxt.phase = PH_WAITING; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
          end else if (sense.exit_barrier_clear) begin
            nxt.latch[A_CONV] = 1'b1;
          end else begin
            nxt.wait_count = cfg.long_wait; nxt.sub_step = SS_FIRST;
          end
        end
        // Phase codes past the conveyor run fall back to waiting.
        default: begin
          nxt.phase = PH_WAITING; nxt.sub_step = SS_ENTRY; nxt.wait_count = '0;
        end
      endcase
    end
  end

endmodule

@@ design/kiln_saw_station_sequencer_unit.sv @@
// Top level of the kiln saw station sequencer: input register, sequencer
// state, result register. Depends on kssq_pkg, kssq_cfg_regs and kssq_step.
`timescale 1ns / 1ps
//
//  Channel | Ports                              | Carries
//  --------+------------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data        | one tick with sensor snapshot
//  result  | out_valid, out_ready, out_data     | actuator word and phase
//  config  | cfg_valid, cfg_ready, cfg_index,   | timing register write
//          | cfg_data                           |
//
// Each beat is held in the input register and is then stepped through the
// sequencer into the result register, from which its result is offered; one
// beat is taken every cycle while results are drained.
// A stalled result holds the result register and the input register fills;
// in_ready drops only when both are full. Synchronous reset puts the station
// in the waiting phase with all actuators off and the timing registers at
// their defaults. Configuration writes are taken in any cycle.

module kiln_saw_station_sequencer_unit
  import kssq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  timing_cfg_t cfg;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  in_beat_t    in_beat_r;
  logic        in_vld_r;
  out_beat_t   out_beat_r;
  logic        out_vld_r;
  logic        out_free;
  logic        step_fire;

  assign cfg_ready = 1'b1;

  // Timing registers.
  kssq_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Sequencer step for the beat in the input register.
  kssq_step u_step (
    .cur   (state_r),
    .sense (in_beat_r),
    .cfg   (cfg),
    .nxt   (state_nxt)
  );

  // Pipeline handshake: the step fires when the result register can take it.
  assign out_free  = !out_vld_r || out_ready;
  assign step_fire = in_vld_r && out_free;
  assign in_ready  = !in_vld_r || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_beat_r <= in_data;
    end
  end

  // Sequencer state advances once per stepped beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_WAITING;
      state_r.sub_step   <= SS_ENTRY;
      state_r.wait_count <= '0;
      state_r.latch      <= '0;
    end else if (step_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= step_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_beat_r.actuator_word <= state_nxt.latch;
      out_beat_r.phase         <= state_nxt.phase;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_beat_r;

  // Every reported word has the compressor on.
  a_comp_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_beat_r.actuator_word[A_COMP])
    else $error("compressor bit clear in result");

  // Reported phase is always a defined station phase.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_beat_r.phase <= PH_CONVEYOR))
    else $error("result phase out of range");

  // While a pause still has more than one tick left, the phase cannot move.
  a_pause_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (step_fire && (state_r.wait_count > TICK_W'(1))) |=> $stable(state_r.phase))
    else $error("phase changed during a pause");

  // Input stalls only when both registers are full and the result is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a full pipeline");

endmodule
